// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion wrappers clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/clcd_pkg.sv =====
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types, constants and init tables of the character LCD controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package clcd_pkg;

  // Frame buffer geometry: two lines of sixteen characters.
  localparam int BUFFER_CHARS = 32;
  localparam int LINE_CHARS   = BUFFER_CHARS / 2;
  localparam int FB_AW        = $clog2(BUFFER_CHARS);
  localparam int COL_W        = $clog2(LINE_CHARS) + 1;
  localparam int INIT_STEPS   = 9;

  // Widths of timing values.
  localparam int WAIT_W  = 26;
  localparam int DELAY_W = 13;

  // Character and command codes.
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] LINE2_OFFSET = 8'h40;

  // Delays in microseconds.
  localparam logic [DELAY_W-1:0] CURSOR_DELAY_US = 13'd37;
  localparam logic [15:0]        POWER_UP_US     = 16'd40000;

  // Input operation codes.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_TICKS_PER_US = 2'd0;
  localparam logic [1:0] REG_SETUP_TICKS  = 2'd1;
  localparam logic [1:0] REG_HALF_TICKS   = 2'd2;

  // Configuration values seen by the sequencer.
  typedef struct packed {
    logic [9:0] ticks_per_us;
    logic [7:0] setup_ticks;
    logic [9:0] half_cycle_ticks;
  } cfg_t;

  // Pin levels and status after one item.
  typedef struct packed {
    logic       rs;
    logic       enable;
    logic [3:0] nibble;
    logic       ready;
  } pins_t;

  // Init table: command byte of each step.
  function automatic logic [7:0] init_byte(input logic [3:0] k);
    logic [7:0] b;
    unique case (k)
      4'd0, 4'd1, 4'd2: b = 8'h30;
      4'd3:             b = 8'h20;
      4'd4:             b = 8'h28;
      4'd5:             b = 8'h0C;
      4'd6:             b = 8'h06;
      4'd7:             b = 8'h01;
      4'd8:             b = 8'h02;
      default:          b = 8'hFF;
    endcase
    return b;
  endfunction

  // Init table: the first four steps send the upper nibble only.
  function automatic logic init_single(input logic [3:0] k);
    return (k < 4'd4);
  endfunction

  // Init table: wait after each step in microseconds.
  function automatic logic [DELAY_W-1:0] init_us(input logic [3:0] k);
    logic [DELAY_W-1:0] d;
    unique case (k)
      4'd0:                   d = 13'd4100;
      4'd1, 4'd2:             d = 13'd100;
      4'd3, 4'd4, 4'd5, 4'd6: d = 13'd37;
      4'd7:                   d = 13'd2000;
      4'd8:                   d = 13'd1520;
      default:                d = '0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/clcd_ram.sv =====
// ----------------------------------------------------------------------------
// clcd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/clcd_fbuf.sv =====
// ----------------------------------------------------------------------------
// clcd_fbuf
// Frame buffer: RAM plus per-entry valid bits, unwritten entries read as space.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clcd_fbuf
  import clcd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             we_i,
  input  wire logic [FB_AW-1:0] waddr_i,
  input  wire logic [7:0]       wdata_i,
  input  wire logic [FB_AW-1:0] raddr_i,
  output      logic [7:0]       rdata_o
);

  logic [BUFFER_CHARS-1:0] valid_q;
  logic                    rvalid_q;
  logic [7:0]              ram_rdata;

  // Character storage.
  clcd_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_CHARS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we_i),
    .waddr_i(waddr_i),
    .wdata_i(wdata_i),
    .raddr_i(raddr_i),
    .rdata_o(ram_rdata)
  );

  // Valid bits track written entries; the read side samples them with the RAM.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  // An entry never written since reset holds a space.
  assign rdata_o = rvalid_q ? ram_rdata : SPACE_CHAR;

endmodule

`default_nettype wire

// ===== rtl/core/clcd_seq.sv =====
// ----------------------------------------------------------------------------
// clcd_seq
// Display sequencer: power-up wait, init table, refresh and nibble timing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module clcd_seq
  import clcd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             tick_i,
  input  wire cfg_t             cfg_i,
  output      logic [FB_AW-1:0] fb_raddr_o,
  input  wire logic [7:0]       fb_rdata_i,
  output      pins_t            pins_nxt_o
);

  typedef enum logic [1:0] {PH_POWER, PH_INIT, PH_ALIVE, PH_WRITE} phase_e;
  typedef enum logic [1:0] {ST_SETUP, ST_HIGH, ST_LOW} step_e;
  typedef enum logic [1:0] {MODE_NONE, MODE_CTRL, MODE_DATA} mode_e;

  phase_e             phase_q, phase_d, ret_q, ret_d;
  step_e              step_q, step_d;
  mode_e              mode_q, mode_d;
  logic               single_q, single_d;
  logic [7:0]         byte_q, byte_d;
  logic [DELAY_W-1:0] delay_q, delay_d;
  logic [3:0]         init_q, init_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic               row_q, row_d;
  logic [WAIT_W-1:0]  wait_q, wait_d;
  logic               rs_q, rs_d, en_q, en_d;
  logic [3:0]         nib_q, nib_d;
  logic               load_q, load_d;

  // Issue request built by the phase logic.
  logic               iss_en, iss_single, iss_load;
  logic [7:0]         iss_byte;
  mode_e              iss_mode;
  logic [DELAY_W-1:0] iss_delay;
  phase_e             iss_ret;

  logic [7:0]         byte_cur;
  logic [15:0]        mul_a;
  logic [WAIT_W-1:0]  prod, half_w, post_wait;

  // Conditions used by the checks at the end of the module.
  logic               nib_low_phase, data_xfer;

  // A data byte read from the buffer arrives in the cycle after its issue.
  assign byte_cur   = load_q ? fb_rdata_i : byte_q;
  assign fb_raddr_o = {row_q, col_q[COL_W-2:0]};

  // One multiplier serves the power-up wait and the post-byte wait.
  assign mul_a     = (phase_q == PH_POWER) ? POWER_UP_US : 16'(delay_q);
  assign prod      = WAIT_W'(mul_a) * WAIT_W'(cfg_i.ticks_per_us);
  assign half_w    = WAIT_W'(cfg_i.half_cycle_ticks);
  assign post_wait = (prod > half_w) ? prod : half_w;

  // Next-state logic, advanced by one tick beat.
  always_comb begin
    phase_d  = phase_q;
    ret_d    = ret_q;
    step_d   = step_q;
    mode_d   = mode_q;
    single_d = single_q;
    byte_d   = byte_cur;
    delay_d  = delay_q;
    init_d   = init_q;
    col_d    = col_q;
    row_d    = row_q;
    wait_d   = wait_q;
    rs_d     = rs_q;
    en_d     = en_q;
    nib_d    = nib_q;
    load_d   = 1'b0;

    iss_en     = 1'b0;
    iss_single = 1'b0;
    iss_load   = 1'b0;
    iss_byte   = '0;
    iss_mode   = MODE_CTRL;
    iss_delay  = '0;
    iss_ret    = PH_ALIVE;

    if (tick_i) begin
      if (wait_q != '0) begin
        wait_d = wait_q - WAIT_W'(1);
      end else begin
        unique case (phase_q)
          PH_POWER: begin
            init_d  = '0;
            phase_d = PH_INIT;
            wait_d  = prod;
          end
          PH_INIT: begin
            if (init_q < 4'(INIT_STEPS)) begin
              init_d     = init_q + 4'd1;
              iss_en     = 1'b1;
              iss_byte   = init_byte(init_q);
              iss_single = init_single(init_q);
              iss_delay  = init_us(init_q);
              iss_ret    = PH_INIT;
            end else begin
              phase_d = PH_ALIVE;
            end
          end
          PH_ALIVE: begin
            iss_en = 1'b1;
            if (col_q >= COL_W'(LINE_CHARS)) begin
              // Cursor to the start of the current line.
              col_d     = '0;
              iss_byte  = CMD_SET_ADDR | (row_q ? LINE2_OFFSET : 8'h00);
              iss_delay = CURSOR_DELAY_US;
            end else begin
              // Next character of the line, fetched from the frame buffer.
              col_d    = col_q + COL_W'(1);
              iss_mode = MODE_DATA;
              iss_load = 1'b1;
              if (col_q == COL_W'(LINE_CHARS - 1)) begin
                row_d = ~row_q;
              end
            end
          end
          PH_WRITE: begin
            if (step_q == ST_SETUP) begin
              rs_d   = (mode_q == MODE_DATA);
              step_d = ST_HIGH;
              wait_d = WAIT_W'(cfg_i.setup_ticks);
            end else if (step_q == ST_HIGH) begin
              nib_d  = byte_cur[7:4];
              en_d   = 1'b1;
              step_d = ST_LOW;
              wait_d = half_w;
            end else begin
              en_d   = 1'b0;
              step_d = ST_HIGH;
              if (!single_q) begin
                single_d = 1'b1;
                byte_d   = {byte_cur[3:0], 4'h0};
                wait_d   = half_w;
              end else begin
                wait_d  = post_wait;
                phase_d = ret_q;
              end
            end
          end
          default: phase_d = PH_POWER;
        endcase
      end
    end

    // Start a byte transfer, with a select setup only on a mode change.
    if (iss_en) begin
      byte_d   = iss_byte;
      load_d   = iss_load;
      single_d = iss_single;
      delay_d  = iss_delay;
      ret_d    = iss_ret;
      phase_d  = PH_WRITE;
      if (mode_q != iss_mode) begin
        mode_d = iss_mode;
        step_d = ST_SETUP;
      end else begin
        step_d = ST_HIGH;
      end
    end
  end

  // Pin levels after the current item.
  always_comb begin
    pins_nxt_o.rs     = rs_d;
    pins_nxt_o.enable = en_d;
    pins_nxt_o.nibble = nib_d;
    pins_nxt_o.ready  = (phase_d == PH_ALIVE) ||
                        ((phase_d == PH_WRITE) && (ret_d == PH_ALIVE));
  end

  // State and pin registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_POWER;
      ret_q    <= PH_POWER;
      step_q   <= ST_SETUP;
      mode_q   <= MODE_NONE;
      single_q <= 1'b0;
      byte_q   <= '0;
      delay_q  <= '0;
      init_q   <= '0;
      col_q    <= COL_W'(LINE_CHARS);
      row_q    <= 1'b0;
      wait_q   <= '0;
      rs_q     <= 1'b0;
      en_q     <= 1'b0;
      nib_q    <= '0;
      load_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      ret_q    <= ret_d;
      step_q   <= step_d;
      mode_q   <= mode_d;
      single_q <= single_d;
      byte_q   <= byte_d;
      delay_q  <= delay_d;
      init_q   <= init_d;
      col_q    <= col_d;
      row_q    <= row_d;
      wait_q   <= wait_d;
      rs_q     <= rs_d;
      en_q     <= en_d;
      nib_q    <= nib_d;
      load_q   <= load_d;
    end
  end

  // A nibble pulse is in its high half, and a data byte of the refresh loop is in flight.
  assign nib_low_phase = (phase_q == PH_WRITE) && (step_q == ST_LOW);
  assign data_xfer     = (phase_q == PH_WRITE) && (mode_q == MODE_DATA) &&
                         (ret_q == PH_ALIVE);

  // Enable is high only between the high and low halves of a nibble.
  `ASSERT_IMPLIES(a_en_in_pulse, en_q, nib_low_phase, "enable high outside a nibble pulse")
  // A pending buffer fetch belongs to a data transfer of the refresh loop.
  `ASSERT_IMPLIES(a_load_data, load_q, data_xfer, "buffer fetch outside a data transfer")
  // The init step never runs past the end of the table.
  `ASSERT_ALWAYS(a_init_range, init_q <= 4'(INIT_STEPS), "init step beyond table")

endmodule

`default_nettype wire

// ===== rtl/core/char_lcd_refresh_controller.sv =====
// ----------------------------------------------------------------------------
// char_lcd_refresh_controller
// HD44780-style 2x16 character LCD refresh controller on a 4-bit bus.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry either one time tick (op_i low) or a write of char_value_i
//   into the 32-entry frame buffer at char_index_i (indexes of 32 or more are
//   dropped). Every input beat yields exactly one output beat carrying the LCD
//   pin levels and display_ready_o as they stand after that beat.
//   An accepted beat is registered in the output or skid register, and one
//   beat is accepted per clock cycle while in_ready_o is high; the frame
//   buffer RAM is read when a data byte issues and the read word is forwarded.
//   The output side has a main register and a skid register: while the
//   receiver stalls, one more input beat is taken, after which in_ready_o
//   drops until the main register drains.
//   Reset clears the sequencer and the buffer valid bits, so every buffer
//   entry reads as a space at once; the first tick starts the 40 ms power-up
//   wait, then the init table runs and refresh follows without end.
//   Registers (APB, byte address 4*i): ticks_per_us, setup_ticks,
//   half_cycle_ticks; write them only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module char_lcd_refresh_controller
  import clcd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  // Input channel
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic        op_i,
  input  wire logic [7:0]  char_value_i,
  input  wire logic [5:0]  char_index_i,
  // Output channel
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic        lcd_rs_o,
  output      logic        lcd_enable_o,
  output      logic [3:0]  lcd_nibble_o,
  output      logic        display_ready_o
);

  cfg_t             cfg_q;
  logic             cfg_we;
  logic             accept, tick, fb_we;
  logic [FB_AW-1:0] fb_raddr;
  logic [7:0]       fb_rdata;
  pins_t            pins_nxt;
  logic             out_valid_q, skid_valid_q;
  pins_t            out_q, skid_q;
  logic             pop;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_us     <= 10'd50;
      cfg_q.setup_ticks      <= 8'd3;
      cfg_q.half_cycle_ticks <= 10'd25;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_TICKS_PER_US: cfg_q.ticks_per_us     <= pwdata[9:0];
        REG_SETUP_TICKS:  cfg_q.setup_ticks      <= pwdata[7:0];
        REG_HALF_TICKS:   cfg_q.half_cycle_ticks <= pwdata[9:0];
        default:          ;
      endcase
    end
  end

  // Register read data.
  always_comb begin
    unique case (paddr[3:2])
      REG_TICKS_PER_US: prdata = {22'd0, cfg_q.ticks_per_us};
      REG_SETUP_TICKS:  prdata = {24'd0, cfg_q.setup_ticks};
      REG_HALF_TICKS:   prdata = {22'd0, cfg_q.half_cycle_ticks};
      default:          prdata = '0;
    endcase
  end

  // Input beat decode.
  assign in_ready_o = ~skid_valid_q;
  assign accept     = in_valid_i & in_ready_o;
  assign tick       = accept & (op_i == OP_TICK);
  assign fb_we      = accept & (op_i == OP_WRITE) & ~char_index_i[5];

  clcd_fbuf u_fbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (fb_we),
    .waddr_i(char_index_i[FB_AW-1:0]),
    .wdata_i(char_value_i),
    .raddr_i(fb_raddr),
    .rdata_o(fb_rdata)
  );

  clcd_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (tick),
    .cfg_i     (cfg_q),
    .fb_raddr_o(fb_raddr),
    .fb_rdata_i(fb_rdata),
    .pins_nxt_o(pins_nxt)
  );

  // Output register with a skid stage behind it.
  assign pop = out_valid_q & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_q <= skid_valid_q ? skid_q : pins_nxt;
    end else if (accept) begin
      skid_q <= pins_nxt;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign lcd_rs_o        = out_q.rs;
  assign lcd_enable_o    = out_q.enable;
  assign lcd_nibble_o    = out_q.nibble;
  assign display_ready_o = out_q.ready;

  // The skid stage is only used behind a full output register.
  `ASSERT_IMPLIES(a_skid_behind_main, skid_valid_q, out_valid_q, "skid full with output empty")
  // Every accepted beat leaves a result waiting in the output register.
  `ASSERT_NEXT(a_accept_fills, accept, out_valid_q, "accepted beat lost")
  // A write beat never advances the sequencer.
  `ASSERT_IMPLIES(a_write_no_tick, fb_we, !tick, "write treated as tick")

endmodule

`default_nettype wire
